### src/multi_mode_search_fringe_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef MULTI_MODE_SEARCH_FRINGE_UNIT_MACROS_SVH
`define MULTI_MODE_SEARCH_FRINGE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MMSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MMSF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/mmsf_pkg.sv
// ---------------------------------------------------------------------------
// mmsf_pkg
// Shared constants and types of the multi-mode search fringe.
// ---------------------------------------------------------------------------
`default_nettype none
package mmsf_pkg;
  localparam int DEPTH        = 1024;
  localparam int COST_BITS    = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int AW           = $clog2(DEPTH);
  localparam int CW           = $clog2(DEPTH + 1);
  localparam int EW           = COST_BITS + PAYLOAD_BITS;

  localparam logic [1:0] MODE_STACK = 2'd0;
  localparam logic [1:0] MODE_FIFO  = 2'd1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;

  typedef struct packed {
    logic [COST_BITS-1:0]    cost;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // Memory port bundle from sequencer to RAM.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

### src/multi_mode_search_fringe_unit.sv
// ---------------------------------------------------------------------------
// multi_mode_search_fringe_unit
// Store of up to DEPTH cost/payload entries used as a stack, a FIFO or a
// min-heap on cost, chosen by the mode register written through cfg_data.
// Input beats on in_valid/in_stall carry func, cost and payload; each gives
// exactly one result beat on out_valid/out_stall. in_stall is high from the
// accepting edge until the result beat has been taken, so one item is in
// flight and the next beat is taken in the cycle after the result beat.
// Stack and FIFO operations access one entry and refused operations none;
// heap insert compares the new entry with one parent after another, and
// heap remove reads the root and, unless it empties the store, the last
// entry, which it sifts down level by level, reading both children through
// the single read port of the entry RAM.
// A held out_stall keeps the result stable and the block stalled.
// Reset empties the store by clearing the count and indices; stored data
// is left as it was. The mode register resets to stack; write it only
// while idle.
// ---------------------------------------------------------------------------
`default_nettype none
module multi_mode_search_fringe_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [15:0] in_item_cost,
  input  wire logic [31:0] in_item_payload,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_cost,
  output logic [31:0]      out_payload,
  output logic [1:0]       out_status,
  output logic [10:0]      out_occupancy,
  output logic [10:0]      out_peak_count
);
  logic [1:0]         mode_r;
  mmsf_pkg::mem_req_t mreq;
  mmsf_pkg::entry_t   mrd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= mmsf_pkg::MODE_STACK;
    else if (cfg_valid) mode_r <= cfg_data;
  end

  mmsf_seq u_seq (
    .clk, .rst_n, .mode(mode_r), .in_valid, .in_stall, .in_func, .in_item_cost,
    .in_item_payload, .out_valid, .out_stall, .out_cost, .out_payload, .out_status,
    .out_occupancy, .out_peak_count, .mreq, .mrd
  );
  mmsf_ram u_ram (.clk, .req(mreq), .rdata(mrd));
endmodule
`default_nettype wire

### src/mmsf_ram.sv
// ---------------------------------------------------------------------------
// mmsf_ram
// Entry store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module mmsf_ram (
  input  wire logic              clk,
  input  wire mmsf_pkg::mem_req_t req,
  output mmsf_pkg::entry_t       rdata
);
  mmsf_pkg::entry_t mem [mmsf_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

### src/mmsf_seq.sv
// ---------------------------------------------------------------------------
// mmsf_seq
// Sequencer: a state machine walks the heap over memory cycles, comparing costs.
// ---------------------------------------------------------------------------
`default_nettype none
module mmsf_seq (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [1:0]                     mode,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic [mmsf_pkg::COST_BITS-1:0] in_item_cost,
  input  wire logic [mmsf_pkg::PAYLOAD_BITS-1:0] in_item_payload,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [mmsf_pkg::COST_BITS-1:0]      out_cost,
  output logic [mmsf_pkg::PAYLOAD_BITS-1:0]   out_payload,
  output logic [1:0]                          out_status,
  output logic [mmsf_pkg::CW-1:0]             out_occupancy,
  output logic [mmsf_pkg::CW-1:0]             out_peak_count,
  output mmsf_pkg::mem_req_t                  mreq,
  input  wire mmsf_pkg::entry_t               mrd
);
  localparam int AW = mmsf_pkg::AW;
  localparam int CW = mmsf_pkg::CW;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_WT, S_UP_CMP,
    S_RM_RD, S_RM_WT, S_RM_LAST, S_DN_RD, S_DN_L, S_DN_R, S_DN_CMP, S_OUT
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r, peak_r;
  logic [AW-1:0]    head_r, tail_r;
  logic [CW-1:0]    idx_r;     // current heap node
  logic [CW-1:0]    n_r;       // heap size during sift down
  mmsf_pkg::entry_t cur_r;     // entry being sifted
  mmsf_pkg::entry_t lch_r;
  logic             lok_r;
  logic [1:0]       mode_r;
  mmsf_pkg::mem_req_t mreq_r;
  logic             wr_en;

  logic [CW-1:0] parent, lidx, ridx;
  logic [CW:0]   l_full;
  assign parent = (idx_r - CW'(1)) >> 1;
  assign l_full = {idx_r, 1'b1};
  assign lidx   = l_full[CW-1:0];
  assign ridx   = lidx + CW'(1);

  assign in_stall = (state_r != S_IDLE);
  assign mreq     = mreq_r;

  // Write strobe for the entry RAM, registered with the rest of the request.
  always_comb begin
    wr_en = 1'b0;
    case (state_r)
      S_IDLE:   wr_en = in_valid && (in_func == mmsf_pkg::FUNC_INSERT) &&
                        (count_r < CW'(mmsf_pkg::DEPTH)) && !mode[1];
      S_UP_RD:  wr_en = (idx_r == '0);
      S_UP_CMP: wr_en = 1'b1;
      S_DN_CMP: wr_en = lok_r;
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    mreq_r.we <= rst_n && wr_en;
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; peak_r <= '0; head_r <= '0; tail_r <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          mode_r <= mode;
          out_cost <= '0; out_payload <= '0; out_status <= mmsf_pkg::ST_DONE;
          cur_r <= '{cost: in_item_cost, payload: in_item_payload};
          if (in_func == mmsf_pkg::FUNC_INSERT) begin
            if (count_r >= CW'(mmsf_pkg::DEPTH)) begin
              out_status <= mmsf_pkg::ST_FULL;
              state_r <= S_OUT;
            end else begin
              count_r <= count_r + CW'(1);
              if (count_r + CW'(1) > peak_r) peak_r <= count_r + CW'(1);
              if (mode[1]) begin
                idx_r <= count_r;
                state_r <= S_UP_RD;
              end else begin
                mreq_r.wdata <= '{cost: in_item_cost, payload: in_item_payload};
                if (mode == mmsf_pkg::MODE_FIFO) begin
                  mreq_r.waddr <= tail_r;
                  tail_r <= tail_r + AW'(1);
                end else mreq_r.waddr <= count_r[AW-1:0];
                state_r <= S_OUT;
              end
            end
          end else begin
            if (count_r == '0) begin
              out_status <= mmsf_pkg::ST_EMPTY;
              state_r <= S_OUT;
            end else begin
              count_r <= count_r - CW'(1);
              n_r <= count_r - CW'(1);
              if (mode[1]) mreq_r.raddr <= '0;
              else if (mode == mmsf_pkg::MODE_FIFO) begin
                mreq_r.raddr <= head_r;
                head_r <= head_r + AW'(1);
              end else mreq_r.raddr <= AW'(count_r - CW'(1));
              state_r <= S_RM_RD;
            end
          end
        end
        // sift up: hole at idx_r holds cur_r
        S_UP_RD: begin
          if (idx_r == '0) begin
            mreq_r.waddr <= '0; mreq_r.wdata <= cur_r;
            state_r <= S_OUT;
          end else begin
            mreq_r.raddr <= parent[AW-1:0];
            state_r <= S_UP_WT;
          end
        end
        S_UP_WT: state_r <= S_UP_CMP;
        S_UP_CMP: begin
          mreq_r.waddr <= idx_r[AW-1:0];
          if (cur_r.cost < mrd.cost) begin
            mreq_r.wdata <= mrd;
            idx_r <= parent;
            state_r <= S_UP_RD;
          end else begin
            mreq_r.wdata <= cur_r;
            state_r <= S_OUT;
          end
        end
        S_RM_RD: state_r <= S_RM_WT;
        S_RM_WT: begin
          out_cost <= mrd.cost; out_payload <= mrd.payload;
          if (mode_r[1] && n_r != '0) begin
            mreq_r.raddr <= n_r[AW-1:0];
            state_r <= S_RM_LAST;
          end else state_r <= S_OUT;
        end
        S_RM_LAST: begin idx_r <= '0; lok_r <= 1'b0; state_r <= S_DN_RD; end
        S_DN_RD: begin
          cur_r <= mrd; // last entry, now sifted down from the root
          state_r <= S_DN_L;
        end
        S_DN_L: begin
          mreq_r.raddr <= lidx[AW-1:0];
          state_r <= S_DN_R;
        end
        S_DN_R: begin
          mreq_r.raddr <= ridx[AW-1:0];
          state_r <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (!lok_r) begin
            lch_r <= mrd;
            lok_r <= 1'b1;
          end else begin
            lok_r <= 1'b0;
            mreq_r.waddr <= idx_r[AW-1:0];
            if (ridx < n_r && mrd.cost < cur_r.cost && mrd.cost < lch_r.cost) begin
              mreq_r.wdata <= mrd; idx_r <= ridx; state_r <= S_DN_L;
            end else if (lidx < n_r && lch_r.cost < cur_r.cost) begin
              mreq_r.wdata <= lch_r; idx_r <= lidx; state_r <= S_DN_L;
            end else begin
              mreq_r.wdata <= cur_r; state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_occupancy <= count_r; out_peak_count <= peak_r;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/mmsf_checker.sv
// ---------------------------------------------------------------------------
// mmsf_checker
// Port-level checks of the multi-mode search fringe.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_mode_search_fringe_unit_macros.svh"
module mmsf_port_checks (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_cost,
  input wire logic [10:0] out_occupancy,
  input wire logic [10:0] out_peak_count
);
  logic in_beat, out_held, out_err;
  assign in_beat  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign out_err  = out_valid && (out_status != mmsf_pkg::ST_DONE);

  `MMSF_ASSERT_IMP(a_peak, clk, rst_n, out_valid, out_peak_count >= out_occupancy, "peak low")
  `MMSF_ASSERT_IMP(a_busy, clk, rst_n, out_valid, in_stall, "input open with result pending")
  `MMSF_ASSERT_NXT(a_hold, clk, rst_n, out_held, out_valid && $stable(out_occupancy), "dropped")
  `MMSF_ASSERT_IMP(a_err, clk, rst_n, out_err, out_cost == 16'd0, "error carries data")
  `MMSF_ASSERT_NXT(a_take, clk, rst_n, in_beat, in_stall, "input open after a beat")
endmodule
bind multi_mode_search_fringe_unit mmsf_port_checks u_chk (.*);
`default_nettype wire
